[hdl/wave_equation_stencil_step_defines.svh]
// Assertion macros for the checker of the wave equation stencil block.
`ifndef WAVE_EQUATION_STENCIL_STEP_DEFINES_SVH
`define WAVE_EQUATION_STENCIL_STEP_DEFINES_SVH

// Next-cycle implication that is switched off while reset is asserted.
`define WES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("stencil step check failed");

// Next-cycle implication that is also checked across reset.
`define WES_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("stencil step reset check failed");

`endif

[hdl/wes_pkg.sv]
// Shared constants, codes and pipeline types of the wave equation stencil block.
`default_nettype none

package wes_pkg;

  localparam int MAX_COLS   = 512;
  localparam int MAX_ROWS   = 512;
  localparam int VALUE_BITS = 16;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ADDR_W  = $clog2(MAX_COLS);
  localparam int VAL_W   = VALUE_BITS;
  localparam int SPD_W   = 16;
  localparam int RATIO_W = 16;

  localparam int RATIO_SHIFT = 16;
  localparam int FRAC_SHIFT  = 14;

  // Datapath widths of the update.
  localparam int LAP_W    = VAL_W + 4;
  localparam int SCALED_W = SPD_W + RATIO_W;
  localparam int SQ_W     = 2 * SPD_W;
  localparam int A2_W     = SQ_W - FRAC_SHIFT;
  localparam int PROD_W   = A2_W + 1 + LAP_W;
  localparam int TERM_W   = PROD_W - FRAC_SHIFT;
  localparam int SUM_W    = TERM_W + 2;

  // Stream and configuration port widths.
  localparam int IN_TDATA_W  = 3 * VAL_W + SPD_W;
  localparam int OUT_USED_W  = ROW_W + COL_W + VAL_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [ROW_W-1:0]   LAST_ROW_RST = ROW_W'(400);
  localparam logic [COL_W-1:0]   LAST_COL_RST = COL_W'(400);
  localparam logic [RATIO_W-1:0] RATIO_RST    = RATIO_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAST_ROW = 2'd0,
    CFG_LAST_COL = 2'd1,
    CFG_RATIO    = 2'd2
  } cfg_idx_t;

  // What travels with every grid point through the pipeline.
  typedef struct packed {
    logic                    is_int;
    logic                    is_edge;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] edge_val;
  } tag_t;

  typedef struct packed {
    tag_t                    tag;
    logic signed [LAP_W-1:0] lap;
    logic signed [VAL_W-1:0] center;
    logic signed [VAL_W-1:0] prev_old;
    logic [SPD_W-1:0]        a;
  } front_t;

  typedef struct packed {
    tag_t                    tag;
    logic signed [VAL_W-1:0] value;
  } res_t;

endpackage

`default_nettype wire

[hdl/wes_ram.sv]
// Generic simple dual-port RAM with registered, read-first read port.
`default_nettype none

module wes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire                       re,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/wes_front.sv]
// Front end: configuration, raster counters, line stores, 3x3 window and Laplacian.
`default_nettype none

module wes_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [wes_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [wes_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [wes_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                             fr_valid,
  input  wire                              fr_ready,
  output wes_pkg::front_t                  fr_data
);

  import wes_pkg::*;

  logic [ROW_W-1:0]   last_row_r;
  logic [COL_W-1:0]   last_col_r;
  logic [RATIO_W-1:0] ratio_r;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic                    acc;
  logic signed [VAL_W-1:0] cur_in, prev_in, edge_in;
  logic [SPD_W-1:0]        spd_in;
  tag_t                    tag0;
  logic [ADDR_W-1:0]       addr;

  logic [VAL_W-1:0] bank0_q, bank1_q, prev_q;
  logic [SPD_W-1:0] spd_q;

  logic                    v1_r;
  tag_t                    tag1_r;
  logic signed [VAL_W-1:0] cur1_r;

  logic signed [VAL_W-1:0] top_now, mid_now;
  logic signed [VAL_W-1:0] w_top_r, w_mid_r, w_left_r, w_bot_r, w_prev_r;
  logic [SPD_W-1:0]        w_spd_r;

  logic signed [LAP_W-1:0] lap;
  logic [SCALED_W-1:0]     a_full;

  logic   v2_r;
  front_t fr_r, fr_nxt;
  logic   s2_en, s1_free;

  // Configuration is always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_row_r <= LAST_ROW_RST;
      last_col_r <= LAST_COL_RST;
      ratio_r    <= RATIO_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LAST_ROW: last_row_r <= cfg_data[ROW_W-1:0];
        CFG_LAST_COL: last_col_r <= cfg_data[COL_W-1:0];
        CFG_RATIO:    ratio_r    <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: a stage loads when it is empty or the one after it is empty or moving.
  assign s2_en     = !v2_r || fr_ready;
  assign s1_free   = !v1_r || s2_en;
  assign in_tready = s1_free;
  assign acc       = in_tvalid && s1_free;

  assign cur_in  = in_tdata[VAL_W-1:0];
  assign prev_in = in_tdata[2*VAL_W-1:VAL_W];
  assign spd_in  = in_tdata[2*VAL_W+SPD_W-1:2*VAL_W];
  assign edge_in = in_tdata[3*VAL_W+SPD_W-1:2*VAL_W+SPD_W];
  assign addr    = ADDR_W'(col_r);

  always_comb begin
    tag0.is_int   = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2)) &&
                    (row_r <= last_row_r) && (col_r <= last_col_r);
    tag0.is_edge  = (row_r == '0) || (row_r >= last_row_r) ||
                    (col_r == '0) || (col_r >= last_col_r);
    tag0.row      = row_r;
    tag0.col      = col_r;
    tag0.edge_val = edge_in;
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r + COL_W'(1);
    if (col_r >= last_col_r) begin
      col_nxt = '0;
      row_nxt = (row_r >= last_row_r) ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // The two current-value lines alternate by row parity; even rows live in bank 0.
  wes_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_cur_bank0 (
    .clk(clk), .we(acc && !row_r[0]), .waddr(addr), .wdata(cur_in),
    .re(acc), .raddr(addr), .rdata(bank0_q)
  );

  wes_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_cur_bank1 (
    .clk(clk), .we(acc && row_r[0]), .waddr(addr), .wdata(cur_in),
    .re(acc), .raddr(addr), .rdata(bank1_q)
  );

  wes_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_prev_line (
    .clk(clk), .we(acc), .waddr(addr), .wdata(prev_in),
    .re(acc), .raddr(addr), .rdata(prev_q)
  );

  wes_ram #(.WIDTH(SPD_W), .DEPTH(MAX_COLS)) u_speed_line (
    .clk(clk), .we(acc), .waddr(addr), .wdata(spd_in),
    .re(acc), .raddr(addr), .rdata(spd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_free) begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      tag1_r <= tag0;
      cur1_r <= cur_in;
    end
  end

  // Row r-2 sits in the bank of the same parity as row r, row r-1 in the other.
  assign top_now = tag1_r.row[0] ? bank1_q : bank0_q;
  assign mid_now = tag1_r.row[0] ? bank0_q : bank1_q;

  // The window still holds the previous point's column while this one is computed.
  assign lap = LAP_W'(w_top_r) + LAP_W'(w_bot_r) + LAP_W'(w_left_r) + LAP_W'(mid_now)
             - (LAP_W'(w_mid_r) <<< 2);
  assign a_full = w_spd_r * ratio_r;

  always_comb begin
    fr_nxt.tag      = tag1_r;
    fr_nxt.lap      = lap;
    fr_nxt.center   = w_mid_r;
    fr_nxt.prev_old = w_prev_r;
    fr_nxt.a        = a_full[SCALED_W-1:RATIO_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && v1_r) begin
      fr_r     <= fr_nxt;
      w_left_r <= w_mid_r;
      w_top_r  <= top_now;
      w_mid_r  <= mid_now;
      w_bot_r  <= cur1_r;
      w_prev_r <= prev_q;
      w_spd_r  <= spd_q;
    end
  end

  assign fr_valid = v2_r;
  assign fr_data  = fr_r;

endmodule

`default_nettype wire

[hdl/wes_arith.sv]
// Arithmetic back end: coefficient square, Laplacian product, sum and saturation.
`default_nettype none

module wes_arith (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                fr_valid,
  output logic               fr_ready,
  input  wes_pkg::front_t    fr_data,
  output logic               res_valid,
  input  wire                res_ready,
  output wes_pkg::res_t      res_data
);

  import wes_pkg::*;

  typedef struct packed {
    tag_t                    tag;
    logic [A2_W-1:0]         a2;
    logic signed [LAP_W-1:0] lap;
    logic signed [VAL_W-1:0] center;
    logic signed [VAL_W-1:0] prev_old;
  } sq_stage_t;

  typedef struct packed {
    tag_t                     tag;
    logic signed [PROD_W-1:0] prod;
    logic signed [VAL_W-1:0]  center;
    logic signed [VAL_W-1:0]  prev_old;
  } mul_stage_t;

  logic       v3_r, v4_r, v5_r;
  logic       en3, en4, en5;
  sq_stage_t  p3_r;
  mul_stage_t p4_r;
  res_t       p5_r;

  logic [SQ_W-1:0]          sq;
  logic signed [PROD_W-1:0] prod;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_W-1:0]  nv;
  logic                     ovf;
  logic signed [VAL_W-1:0]  sat;

  assign en5      = !v5_r || res_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign fr_ready = en3;

  assign sq   = fr_data.a * fr_data.a;
  assign prod = $signed({1'b0, p3_r.a2}) * p3_r.lap;

  // Arithmetic shift of the product floors toward minus infinity.
  assign term = p4_r.prod[PROD_W-1:FRAC_SHIFT];
  assign nv   = (SUM_W'(p4_r.center) <<< 1) - SUM_W'(p4_r.prev_old) + SUM_W'(term);

  // Overflow when the bits above the result's sign are not all copies of it.
  assign ovf = !((&nv[SUM_W-1:VAL_W-1]) || (~|nv[SUM_W-1:VAL_W-1]));
  assign sat = !ovf ? nv[VAL_W-1:0] :
               nv[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en3) v3_r <= fr_valid;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && fr_valid) begin
      p3_r.tag      <= fr_data.tag;
      p3_r.a2       <= sq[SQ_W-1:FRAC_SHIFT];
      p3_r.lap      <= fr_data.lap;
      p3_r.center   <= fr_data.center;
      p3_r.prev_old <= fr_data.prev_old;
    end
    if (en4 && v3_r) begin
      p4_r.tag      <= p3_r.tag;
      p4_r.prod     <= prod;
      p4_r.center   <= p3_r.center;
      p4_r.prev_old <= p3_r.prev_old;
    end
    if (en5 && v4_r) begin
      p5_r.tag   <= p4_r.tag;
      p5_r.value <= sat;
    end
  end

  assign res_valid = v5_r;
  assign res_data  = p5_r;

endmodule

`default_nettype wire

[hdl/wes_out.sv]
// Output stage: sends each point's interior result, if any, and then its edge result, if any.
`default_nettype none

module wes_out (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              res_valid,
  output logic                             res_ready,
  input  wes_pkg::res_t                    res_data,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [wes_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);

  import wes_pkg::*;

  logic             int_pend_r, edge_pend_r;
  res_t             hold_r;
  logic [ROW_W-1:0] o_row;
  logic [COL_W-1:0] o_col;
  logic [VAL_W-1:0] o_val;

  assign out_tvalid = int_pend_r || edge_pend_r;
  assign out_tlast  = !(int_pend_r && edge_pend_r);
  assign res_ready  = !out_tvalid || (out_tready && out_tlast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_pend_r  <= 1'b0;
      edge_pend_r <= 1'b0;
    end else if (res_ready) begin
      int_pend_r  <= res_valid && res_data.tag.is_int;
      edge_pend_r <= res_valid && res_data.tag.is_edge;
    end else if (out_tready) begin
      // Only a pair can be waiting here; its interior half has gone out.
      int_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      hold_r <= res_data;
    end
  end

  // An interior result names the point one row up and one column left.
  assign o_row = int_pend_r ? hold_r.tag.row - ROW_W'(1) : hold_r.tag.row;
  assign o_col = int_pend_r ? hold_r.tag.col - COL_W'(1) : hold_r.tag.col;
  assign o_val = int_pend_r ? hold_r.value : hold_r.tag.edge_val;

  assign out_tdata = {{OUT_PAD_W{1'b0}}, o_val, o_col, o_row};

endmodule

`default_nettype wire

[hdl/wave_equation_stencil_step.sv]
// Top level of the streaming 2-D wave equation stencil step.
//
// Grid points enter on the in_ stream in raster order, one transaction per point:
// tdata carries the current value, the previous value, the wave speed and the edge
// value. Each point yields zero, one or two transactions on the out_ stream: the
// updated interior point one row up and one column left, then the point itself if
// it lies on the grid edge. out_tlast marks the final transaction of each point.
// The cfg_ port writes the last row index, last column index and Courant ratio;
// it is always ready. The user must write it only while the stream is idle; the
// block does not enforce this. Results of point (r,c) pass through the front and
// arithmetic pipeline registers to the output register. One point is accepted per
// cycle unless the output holds the stream back; a point that yields two results
// holds the single output port for both, and these are the last column of every
// row from row 2 on and every point of the last row from column 2 on.
// Reset clears the row and column counters, the valid bits and the configuration
// registers; the line memories are not cleared.
// When the receiver stalls, results wait in the pipeline registers and input is
// refused only once every stage is full.
`default_nettype none

module wave_equation_stencil_step (
  input  wire                              clk,
  input  wire                              rst_n,
  // in_tdata: current_value, previous_value, wave_speed, edge_value
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [wes_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: out_row, out_col, next_value, zero fill
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [wes_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [wes_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [wes_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import wes_pkg::*;

  logic   fr_valid, fr_ready;
  front_t fr_data;
  logic   res_valid, res_ready;
  res_t   res_data;

  wes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fr_valid  (fr_valid),
    .fr_ready  (fr_ready),
    .fr_data   (fr_data)
  );

  wes_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .fr_valid  (fr_valid),
    .fr_ready  (fr_ready),
    .fr_data   (fr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  wes_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[hdl/wes_checker.sv]
// Port-level checker for the wave equation stencil step, bound to the top level.
`default_nettype none
`include "wave_equation_stencil_step_defines.svh"

module wes_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [wes_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire                              out_tlast
);

  import wes_pkg::*;

  // A stalled result keeps its payload.
  `WES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // The first result of a pair is followed at once by the closing edge result.
  `WES_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tlast)

  // The edge result of a pair lies one row down and one column right of the interior one.
  `WES_ASSERT_NEXT(a_pair_coord, clk, rst_n, out_tvalid && out_tready && !out_tlast, (out_tdata[ROW_W-1:0] == $past(out_tdata[ROW_W-1:0]) + ROW_W'(1)) && (out_tdata[ROW_W+COL_W-1:ROW_W] == $past(out_tdata[ROW_W+COL_W-1:ROW_W]) + COL_W'(1)))

  // Reset empties the output register.
  `WES_ASSERT_NEXT_NR(a_reset_empty, clk, !rst_n, !out_tvalid)

endmodule

bind wave_equation_stencil_step wes_checker u_wes_checker (.*);

`default_nettype wire
